### sv/voxel_surface_detector_defines.svh
// Assertion macros for the voxel surface detector.
`ifndef VOXEL_SURFACE_DETECTOR_DEFINES_SVH
`define VOXEL_SURFACE_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, held off during reset.
`define VSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsd: implication check failed");
// Next-cycle implication, held off during reset.
`define VSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsd: next-cycle check failed");
`else
`define VSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define VSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/vsd_pkg.sv
package vsd_pkg;

    localparam int MAX_X = 32;
    localparam int MAX_Y = 16;
    localparam int MAX_Z = 32;

    // coordinate and size widths
    localparam int XW  = $clog2(MAX_X);
    localparam int YW  = $clog2(MAX_Y);
    localparam int ZW  = $clog2(MAX_Z);
    localparam int SXW = $clog2(MAX_X + 1);
    localparam int SYW = $clog2(MAX_Y + 1);
    localparam int SZW = $clog2(MAX_Z + 1);

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 6;
    localparam int CNT_W  = 14;

    localparam int SLICE_W    = 9;
    localparam int WIN_W      = 3 * SLICE_W;
    localparam int CENTER_BIT = 13;

    localparam int PIDX_W = YW + ZW;
    localparam int PLANE_DEPTH = MAX_Y * MAX_Z;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } t_cfg_idx;

    // Limit a grid extent to 3..hi.
    function automatic logic [CFG_DW-1:0] clamp_size(input logic [CFG_DW-1:0] v,
                                                     input logic [CFG_DW-1:0] hi);
        logic [CFG_DW-1:0] r;
        if (v < CFG_DW'(3)) begin
            r = CFG_DW'(3);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### sv/voxel_surface_detector.sv
// Voxel surface detector: streaming 26-neighbour boundary test.
//
// Input channel (i_valid / o_ready / i_solid): one voxel per word, scan
// order x outermost, then y, z innermost. Output channel (o_valid / i_ready)
// carries one result word per interior voxel: its coordinates, the visible
// flag (solid with at least one air neighbour), the running visible count
// of the frame and a frame_last marker. Border voxels give no result.
//
// One voxel per clock unless a result word is held off (see below). The
// plane history is a 512 x 2 memory whose next-position read is registered
// ahead, so a read-modify-write per voxel fits every cycle. A result shows
// in the cycle after the word with voxel (x+1, y+1, z+1) is taken.
//
// A single output register parts the channels. When it is full and not
// being taken, a word that would produce a result is held off; border
// words are still accepted. Reset (synchronous) restores 20 x 10 x 20 and
// restarts the scan; history stores are not cleared, as every reported voxel
// is judged only from words of its own frame. A size write restarts the scan
// and clears the count; the user issues it only while idle (unenforced).
`include "voxel_surface_detector_defines.svh"

module voxel_surface_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vsd_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [vsd_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_solid,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [vsd_pkg::XW-1:0]      o_center_x,
    output logic [vsd_pkg::YW-1:0]      o_center_y,
    output logic [vsd_pkg::ZW-1:0]      o_center_z,
    output logic                        o_visible,
    output logic [vsd_pkg::CNT_W-1:0]   o_visible_count,
    output logic                        o_frame_last
);
    import vsd_pkg::*;

    // effective (clamped) grid sizes
    logic [SXW-1:0] r_size_x;
    logic [SYW-1:0] r_size_y;
    logic [SZW-1:0] r_size_z;

    // position of the next arriving voxel and frame count
    logic [XW-1:0]    r_scan_x, n_scan_x;
    logic [YW-1:0]    r_scan_y, n_scan_y;
    logic [ZW-1:0]    r_scan_z, n_scan_z;
    logic [CNT_W-1:0] r_seen, n_seen;

    // history stores
    logic [1:0]       r_plane_mem [PLANE_DEPTH];
    logic [1:0]       r_plane_rd;
    logic [5:0]       r_row [MAX_Z];
    logic [WIN_W-1:0] r_window;

    // output register
    logic             r_out_valid;
    logic [XW-1:0]    r_out_x;
    logic [YW-1:0]    r_out_y;
    logic [ZW-1:0]    r_out_z;
    logic             r_out_vis;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_last;

    logic              cfg_hit;
    logic              emit_cur;
    logic              last_cur;
    logic              in_acc;
    logic              out_take;
    logic              z_wrap, y_wrap, x_wrap;
    logic [2:0]        col;
    logic [1:0]        plane_new;
    logic [5:0]        rows;
    logic [5:0]        row_new;
    logic [SLICE_W-1:0] slice;
    logic [WIN_W-1:0]  win_next;
    logic              vis;
    logic [CNT_W-1:0]  seen_inc;
    logic [PIDX_W-1:0] pidx_cur;
    logic [PIDX_W-1:0] pidx_next;

    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_SIZE_X || i_cfg_index == CFG_SIZE_Y
                                  || i_cfg_index == CFG_SIZE_Z);

    // a result is due once the voxel at (x+1, y+1, z+1) arrives
    assign emit_cur = (r_scan_x >= XW'(2)) && (r_scan_y >= YW'(2)) && (r_scan_z >= ZW'(2));
    assign last_cur = (SXW'(r_scan_x) + SXW'(1) >= r_size_x)
                   && (SYW'(r_scan_y) + SYW'(1) >= r_size_y)
                   && (SZW'(r_scan_z) + SZW'(1) >= r_size_z);

    // take border voxels even while a result waits
    assign o_ready  = !emit_cur || !r_out_valid || i_ready;
    assign in_acc   = i_valid && o_ready;
    assign out_take = r_out_valid && i_ready;

    assign z_wrap = SZW'(r_scan_z) + SZW'(1) >= r_size_z;
    assign y_wrap = SYW'(r_scan_y) + SYW'(1) >= r_size_y;
    assign x_wrap = SXW'(r_scan_x) + SXW'(1) >= r_size_x;

    // next scan position; also drives the plane prefetch address
    always_comb begin
        n_scan_x = r_scan_x;
        n_scan_y = r_scan_y;
        n_scan_z = r_scan_z;
        if (!i_rst_n || cfg_hit || (in_acc && last_cur)) begin
            n_scan_x = '0;
            n_scan_y = '0;
            n_scan_z = '0;
        end else if (in_acc) begin
            if (!z_wrap) begin
                n_scan_z = r_scan_z + ZW'(1);
            end else begin
                n_scan_z = '0;
                if (!y_wrap) begin
                    n_scan_y = r_scan_y + YW'(1);
                end else begin
                    n_scan_y = '0;
                    n_scan_x = x_wrap ? '0 : r_scan_x + XW'(1);
                end
            end
        end
    end

    assign pidx_cur  = {r_scan_y, r_scan_z};
    assign pidx_next = {n_scan_y, n_scan_z};

    // column x-2, x-1, x at (y,z): oldest in bit 0
    assign col       = {i_solid, r_plane_rd[0], r_plane_rd[1]};
    assign plane_new = {r_plane_rd[0], i_solid};

    // rows y-2, y-1, y at z: row y-2 lowest
    assign rows    = r_row[r_scan_z];
    assign slice   = {col, rows[2:0], rows[5:3]};
    assign row_new = {rows[2:0], col};

    assign win_next = {r_window[WIN_W-SLICE_W-1:0], slice};
    assign vis      = win_next[CENTER_BIT] && !(&win_next);
    assign seen_inc = r_seen + CNT_W'(vis);

    always_comb begin
        n_seen = r_seen;
        if (cfg_hit || (in_acc && last_cur)) begin
            n_seen = '0;
        end else if (in_acc && emit_cur) begin
            n_seen = seen_inc;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x    <= SXW'(20);
            r_size_y    <= SYW'(10);
            r_size_z    <= SZW'(20);
            r_scan_x    <= '0;
            r_scan_y    <= '0;
            r_scan_z    <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE_X: r_size_x <= SXW'(clamp_size(i_cfg_data, CFG_DW'(MAX_X)));
                    CFG_SIZE_Y: r_size_y <= SYW'(clamp_size({1'b0, i_cfg_data[4:0]},
                                                            CFG_DW'(MAX_Y)));
                    CFG_SIZE_Z: r_size_z <= SZW'(clamp_size(i_cfg_data, CFG_DW'(MAX_Z)));
                    default: ;
                endcase
            end
            r_scan_x <= n_scan_x;
            r_scan_y <= n_scan_y;
            r_scan_z <= n_scan_z;
            r_seen   <= n_seen;
            if (in_acc && emit_cur) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // plane history: write the current column, prefetch the next one
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_plane_mem[pidx_cur] <= plane_new;
        end
        r_plane_rd <= r_plane_mem[pidx_next];
    end

    // row history, window and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row[r_scan_z] <= row_new;
            r_window        <= win_next;
        end
        if (in_acc && emit_cur) begin
            r_out_x    <= r_scan_x - XW'(1);
            r_out_y    <= r_scan_y - YW'(1);
            r_out_z    <= r_scan_z - ZW'(1);
            r_out_vis  <= vis;
            r_out_cnt  <= seen_inc;
            r_out_last <= last_cur;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_center_x      = r_out_x;
    assign o_center_y      = r_out_y;
    assign o_center_z      = r_out_z;
    assign o_visible       = r_out_vis;
    assign o_visible_count = r_out_cnt;
    assign o_frame_last    = r_out_last;

    // the frame's last result sits at the far interior corner
    `VSD_ASSERT_IMPLY(a_last_corner, i_clk, i_rst_n, r_out_valid && r_out_last, (SXW'(r_out_x) + SXW'(2) == r_size_x) && (SYW'(r_out_y) + SYW'(2) == r_size_y) && (SZW'(r_out_z) + SZW'(2) == r_size_z))
    // a visible voxel is always counted
    `VSD_ASSERT_IMPLY(a_vis_counted, i_clk, i_rst_n, r_out_valid && r_out_vis, r_out_cnt != '0)
    // the end of a frame restarts scan and count
    `VSD_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, in_acc && last_cur, r_scan_x == '0 && r_scan_y == '0 && r_scan_z == '0 && r_seen == '0)

endmodule

### bench/tb_voxel_surface_detector.sv
`timescale 1ns / 1ps

module tb_voxel_surface_detector;

    import vsd_pkg::*;

    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 8;      // quiet cycles in a row before the block counts as idle
    localparam int LONG_HOLD    = 400;
    localparam int TIMEOUT_NS   = 50_000_000;

    // Index with no register behind it; the block must ignore it.
    localparam logic [CFG_AW-1:0] CFG_IDX_SPARE = 2'd3;

    // One result word as the output channel carries it.
    typedef struct packed {
        logic [XW-1:0]    cx;
        logic [YW-1:0]    cy;
        logic [ZW-1:0]    cz;
        logic             vis;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_surf_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_index = '0;
    logic [CFG_DW-1:0]  i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_solid = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [XW-1:0]      o_center_x;
    logic [YW-1:0]      o_center_y;
    logic [ZW-1:0]      o_center_z;
    logic               o_visible;
    logic [CNT_W-1:0]   o_visible_count;
    logic               o_frame_last;

    voxel_surface_detector uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_solid         (i_solid),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_center_x      (o_center_x),
        .o_center_y      (o_center_y),
        .o_center_z      (o_center_z),
        .o_visible       (o_visible),
        .o_visible_count (o_visible_count),
        .o_frame_last    (o_frame_last)
    );

    // ------------------------------------------------------------------
    // Surface predictor state: its own copy of sizes, history and window.
    // ------------------------------------------------------------------
    bit [5:0]          raw_x;
    bit [4:0]          raw_y;
    bit [5:0]          raw_z;
    bit [1:0]          plane_hist [PLANE_DEPTH];
    bit [5:0]          row_hist [MAX_Z];
    bit [WIN_W-1:0]    nbhd;
    int                pos_x;
    int                pos_y;
    int                pos_z;
    logic [CNT_W-1:0]  vis_tally;

    t_surf_word        expected_words[$];
    bit                voxel_q[$];

    int                mismatches = 0;
    int                src_gap = 0;
    int                snk_stall = 0;
    bit                quiet_src = 1'b0;
    bit                quiet_snk = 1'b0;
    int                holds_asked = 0;
    int                holds_taken = 0;

    // Free-running clock.
    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Hard limit on run time.
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Effective extent: lift anything below 3, cap at the axis maximum.
    function automatic int eff_size(input int raw, input int hi);
        if (raw < 3) return 3;
        if (raw > hi) return hi;
        return raw;
    endfunction

    // Random idle length: mostly none, sometimes a few cycles, rarely long.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Restart the scan and the visible count, as reset and size writes do.
    task automatic restart_frame();
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        vis_tally = '0;
    endtask

    task automatic reset_predictor();
        raw_x = 6'd20;
        raw_y = 5'd10;
        raw_z = 6'd20;
        foreach (plane_hist[i]) plane_hist[i] = '0;
        foreach (row_hist[i]) row_hist[i] = '0;
        nbhd = '0;
        restart_frame();
    endtask

    // Mirror a register write; an unknown index leaves everything alone.
    task automatic apply_size(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
        bit hit;
        hit = 1'b1;
        case (idx)
            CFG_SIZE_X: raw_x = value;
            CFG_SIZE_Y: raw_y = value[4:0];
            CFG_SIZE_Z: raw_z = value;
            default:    hit = 1'b0;
        endcase
        if (hit) restart_frame();
    endtask

    // Push one voxel through the history stores and the window; queue the
    // result word if the window is centered on an interior voxel.
    task automatic judge_voxel(input bit solid);
        int          sx, sy, sz, a, b, c, pidx;
        bit [1:0]    old;
        bit [2:0]    col;
        bit [5:0]    rows;
        bit [8:0]    slice;
        bit          last;
        bit          vis;
        t_surf_word  w;
        sx = eff_size(raw_x, MAX_X);
        sy = eff_size(raw_y, MAX_Y);
        sz = eff_size(raw_z, MAX_Z);
        a = (pos_x >= MAX_X) ? MAX_X - 1 : pos_x;
        b = (pos_y >= MAX_Y) ? MAX_Y - 1 : pos_y;
        c = (pos_z >= MAX_Z) ? MAX_Z - 1 : pos_z;

        // x column at (b, c): oldest plane in bit 0, arriving voxel in bit 2
        pidx = b * MAX_Z + c;
        old = plane_hist[pidx];
        col = {solid, old[0], old[1]};
        plane_hist[pidx] = {old[0], solid};

        // rows b-2, b-1, b at z = c, oldest row lowest
        rows = row_hist[c];
        slice = {col, rows[2:0], rows[5:3]};
        row_hist[c] = {rows[2:0], col};

        nbhd = {nbhd[WIN_W-SLICE_W-1:0], slice};

        last = (a + 1 >= sx) && (b + 1 >= sy) && (c + 1 >= sz);
        if (a >= 2 && b >= 2 && c >= 2) begin
            vis = nbhd[CENTER_BIT] && (nbhd != {WIN_W{1'b1}});
            if (vis) vis_tally = vis_tally + 1'b1;
            w.cx    = XW'(a - 1);
            w.cy    = YW'(b - 1);
            w.cz    = ZW'(c - 1);
            w.vis   = vis;
            w.count = vis_tally;
            w.last  = last;
            expected_words = {expected_words, w};
        end

        // advance the scan, z fastest
        c++;
        if (c >= sz) begin
            c = 0;
            b++;
            if (b >= sy) begin
                b = 0;
                a++;
                if (a >= sx) a = 0;
            end
        end
        pos_x = a;
        pos_y = b;
        pos_z = c;
        if (last) restart_frame();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued voxels, hold each word until taken, then idle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_voxels
        logic nxt_valid;
        logic nxt_solid;
        int   nxt_gap;
        nxt_valid = i_valid;
        nxt_solid = i_solid;
        nxt_gap   = src_gap;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            // predict on acceptance, in acceptance order
            if (i_valid && o_ready) begin
                judge_voxel(i_solid);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (nxt_gap > 0) begin
                    nxt_gap--;
                end else if (voxel_q.size() > 0) begin
                    nxt_solid = voxel_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_gap   = quiet_src ? 0 : idle_span();
                end
            end
        end
        i_valid <= nxt_valid;
        i_solid <= nxt_solid;
        src_gap <= nxt_gap;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result word with the oldest prediction,
    // and throttle i_ready, including long holds on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_surf_word want;
        logic       nxt_ready;
        int         nxt_stall;
        nxt_ready = i_ready;
        nxt_stall = snk_stall;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word (%0d,%0d,%0d) with nothing predicted",
                       o_center_x, o_center_y, o_center_z);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("center_x", want.cx, o_center_x);
                check_field("center_y", want.cy, o_center_y);
                check_field("center_z", want.cz, o_center_z);
                check_field("visible", want.vis, o_visible);
                check_field("visible_count", want.count, o_visible_count);
                check_field("frame_last", want.last, o_frame_last);
            end
        end
        if (holds_taken != holds_asked) begin
            // start a long hold so the output register backs up into the input
            holds_taken++;
            nxt_ready = 1'b0;
            nxt_stall = LONG_HOLD;
        end else if (nxt_stall > 0) begin
            nxt_ready = 1'b0;
            nxt_stall--;
        end else begin
            nxt_ready = 1'b1;
            nxt_stall = quiet_snk ? 0 : idle_span();
        end
        i_ready   <= nxt_ready;
        snk_stall <= nxt_stall;
    end

    // Queue voxels with the given percentage of air.
    task automatic queue_voxels(input int count, input int air_pct);
        repeat (count) voxel_q = {voxel_q, bit'($urandom_range(0, 99) >= air_pct)};
    endtask

    // Wait until every voxel is taken and every result has come, and the
    // block has then stayed quiet long enough to count as idle.
    task automatic settle();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN_CYCLES) begin
            @(posedge i_clk);
            if (voxel_q.size() != 0 || i_valid || o_valid || expected_words.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_size(idx, value);
    endtask

    // Pick a density for one frame: all solid, all air, or a mix.
    function automatic int pick_air();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 100;
            2:       return 5;
            3:       return 15;
            4:       return 30;
            default: return 60;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int items_sent;
        int phase;
        int frame_len;
        int n_frames;
        int cut;
        int kind;
        bit hold_phase;
        logic [CFG_DW-1:0] vx, vy, vz;

        items_sent = 0;
        phase = 0;
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Start a frame at the reset extents, then abandon it.
        queue_voxels(3, 50);
        settle();

        // Drive sizes below range on every axis: all clamp to 3.
        write_reg(CFG_SIZE_X, 6'd0);
        write_reg(CFG_SIZE_Y, 6'd1);
        write_reg(CFG_SIZE_Z, 6'd2);

        // Minimum cube: air only at the origin corner, so the single
        // interior voxel is solid with one air neighbor.
        voxel_q = {voxel_q, 1'b0};
        repeat (12) voxel_q = {voxel_q, 1'b1};
        settle();
        // A write to the spare index mid-frame must not restart the scan.
        write_reg(CFG_IDX_SPARE, 6'd5);
        repeat (14) voxel_q = {voxel_q, 1'b1};
        settle();

        // Drive sizes above range: capped at the maxima (y drops its top bit).
        write_reg(CFG_SIZE_X, 6'd63);
        write_reg(CFG_SIZE_Y, 6'd63);
        write_reg(CFG_SIZE_Z, 6'd63);
        queue_voxels(6, 50);
        settle();

        while (items_sent < RANDOM_ITEMS) begin
            phase++;
            hold_phase = (phase % 10 == 4);
            quiet_src = ($urandom_range(0, 3) == 0);
            quiet_snk = ($urandom_range(0, 3) == 0);

            // Choose raw extents: mostly small, some below range, some at
            // or above the maximum. Hold phases stay small.
            kind = hold_phase ? 9 : $urandom_range(0, 9);
            vx = CFG_DW'((kind == 0) ? $urandom_range(0, 2) :
                         (kind == 1) ? $urandom_range(32, 63) : $urandom_range(3, 6));
            kind = hold_phase ? 9 : $urandom_range(0, 9);
            vy = CFG_DW'((kind == 0) ? $urandom_range(0, 2) :
                         (kind == 1) ? $urandom_range(16, 63) : $urandom_range(3, 5));
            kind = hold_phase ? 9 : $urandom_range(0, 9);
            vz = CFG_DW'((kind == 0) ? $urandom_range(0, 2) :
                         (kind == 1) ? $urandom_range(32, 63) : $urandom_range(3, 8));

            // Skip a register now and then so old values carry over.
            if ($urandom_range(0, 3) != 0) write_reg(CFG_SIZE_X, vx);
            if ($urandom_range(0, 3) != 0) write_reg(CFG_SIZE_Y, vy);
            if ($urandom_range(0, 3) != 0) write_reg(CFG_SIZE_Z, vz);
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IDX_SPARE, CFG_DW'($urandom_range(0, 63)));

            frame_len = eff_size(raw_x, MAX_X) * eff_size(raw_y, MAX_Y)
                      * eff_size(raw_z, MAX_Z);
            if (hold_phase) holds_asked++;

            if (frame_len > 400) begin
                // Large grid: run only part of it; the next write restarts.
                cut = $urandom_range(40, 250);
                queue_voxels(cut, pick_air());
                items_sent += cut;
            end else begin
                n_frames = $urandom_range(1, 3);
                for (int f = 0; f < n_frames; f++) begin
                    cut = frame_len;
                    // Occasionally break the last frame off early.
                    if (f == n_frames - 1 && $urandom_range(0, 7) == 0)
                        cut = $urandom_range(1, frame_len - 1);
                    queue_voxels(cut, pick_air());
                    items_sent += cut;
                end
            end
            settle();
        end

        settle();
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
